// File: rtl/brd_pkg.sv
package brd_pkg;

    // Operation codes carried in the func field.
    typedef enum logic [1:0] {
        FUNC_REGISTER = 2'd0,
        FUNC_READ     = 2'd1,
        FUNC_WRITE    = 2'd2,
        FUNC_RELEASE  = 2'd3
    } func_t;

    // Result status codes.
    localparam logic [3:0] ST_REGISTERED = 4'd0;
    localparam logic [3:0] ST_ZERO_SIZE  = 4'd1;
    localparam logic [3:0] ST_OVERLAP    = 4'd2;
    localparam logic [3:0] ST_FULL       = 4'd3;
    localparam logic [3:0] ST_ROUTED     = 4'd4;
    localparam logic [3:0] ST_NO_HANDLER = 4'd5;
    localparam logic [3:0] ST_UNMAPPED   = 4'd6;
    localparam logic [3:0] ST_CROSSES    = 4'd7;
    localparam logic [3:0] ST_RELEASED   = 4'd8;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the input word, restart the scan
        logic step;     // examine the current entry, advance the index
        logic finish;   // form the result and apply any table update
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;     // the current entry is the final one
        logic hit;      // the scan found its answer early
    } stat_t;

endpackage

// File: rtl/brd_stream_if.sv
interface brd_stream_if #(
    parameter int WIDTH = 8
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: rtl/brd_ctrl.sv
module brd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  brd_pkg::stat_t   stat,
    output brd_pkg::cmd_t    cmd
);

    brd_pkg::state_t state_reg;
    brd_pkg::state_t state_next;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            brd_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = brd_pkg::S_SCAN;
            end
            brd_pkg::S_SCAN:
            begin
                if (stat.last || stat.hit)
                    state_next = brd_pkg::S_FINISH;
            end
            brd_pkg::S_FINISH:
            begin
                state_next = brd_pkg::S_OUT;
            end
            brd_pkg::S_OUT:
            begin
                if (out_ready)
                    state_next = brd_pkg::S_IDLE;
            end
            default:
            begin
                state_next = brd_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        cmd        = '0;
        case (state_reg)
            brd_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            brd_pkg::S_SCAN:
            begin
                cmd.step = 1'b1;
            end
            brd_pkg::S_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            brd_pkg::S_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= brd_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// File: rtl/brd_datapath.sv
module brd_datapath #(
    parameter int REGIONS        = 16,
    parameter int DEVICE_ID_BITS = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  brd_pkg::cmd_t cmd,
    output brd_pkg::stat_t stat,
    input  logic [1:0]    func,
    input  logic          space,
    input  logic [63:0]   address,
    input  logic [63:0]   length,
    input  logic [3:0]    device_id,
    input  logic          has_read,
    input  logic          has_write,
    input  logic [63:0]   write_data,
    output logic [3:0]    status,
    output logic [3:0]    target_device,
    output logic [63:0]   region_offset,
    output logic [63:0]   routed_data,
    output logic [63:0]   read_value
);

    localparam int IW = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(REGIONS - 1);

    // Region table: valid bits in flip-flops, payload fields without reset.
    logic [REGIONS-1:0]      valid_reg;
    logic [63:0]             base_mem  [REGIONS];
    logic [63:0]             size_mem  [REGIONS];
    logic [DEVICE_ID_BITS-1:0] owner_mem [REGIONS];
    logic [REGIONS-1:0]      space_mem;
    logic [REGIONS-1:0]      rd_mem;
    logic [REGIONS-1:0]      wr_mem;

    // Captured request.
    logic [1:0]              func_reg;
    logic                    space_reg;
    logic [63:0]             addr_reg;
    logic [63:0]             len_reg;
    logic [DEVICE_ID_BITS-1:0] dev_reg;
    logic                    hrd_reg;
    logic                    hwr_reg;
    logic [63:0]             data_reg;

    // Scan state.
    logic [IW-1:0]           idx_reg;
    logic                    found_reg;
    logic                    free_found_reg;
    logic [IW-1:0]           free_idx_reg;
    logic [IW-1:0]           match_idx_reg;
    logic [63:0]             off_reg;

    // Result registers.
    logic [3:0]              status_reg;
    logic [3:0]              tdev_reg;
    logic [63:0]             roff_reg;
    logic [63:0]             rdata_reg;
    logic [63:0]             rval_reg;

    // Examination of the current entry.
    logic                    e_valid;
    logic                    e_same;
    logic [63:0]             e_base;
    logic [63:0]             e_size;
    logic [63:0]             diff_ab;
    logic [63:0]             diff_ba;
    logic                    a_ge_b;
    logic                    meet;
    logic                    contains;
    logic                    is_reg;

    assign e_valid  = valid_reg[idx_reg];
    assign e_same   = space_mem[idx_reg] == space_reg;
    assign e_base   = base_mem[idx_reg];
    assign e_size   = size_mem[idx_reg];
    assign a_ge_b   = addr_reg >= e_base;
    assign diff_ab  = addr_reg - e_base;
    assign diff_ba  = e_base - addr_reg;
    assign meet     = a_ge_b ? (diff_ab < e_size) : (diff_ba < len_reg);
    assign contains = a_ge_b && (diff_ab < e_size);
    assign is_reg   = func_reg == brd_pkg::FUNC_REGISTER;

    always_comb
    begin
        stat.last = idx_reg == LAST_IDX;
        stat.hit  = 1'b0;
        if (cmd.step && e_valid && e_same)
        begin
            if (is_reg)
                stat.hit = meet || (len_reg == '0);
            else if (func_reg != brd_pkg::FUNC_RELEASE)
                stat.hit = contains;
        end
    end

    // Scan and table update.
    logic [63:0] m_size;
    logic        crosses;
    logic        can;
    assign m_size  = size_mem[match_idx_reg];
    assign crosses = len_reg > (m_size - off_reg);
    assign can     = (func_reg == brd_pkg::FUNC_WRITE) ? wr_mem[match_idx_reg]
                                                       : rd_mem[match_idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg        <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                if (idx_reg != LAST_IDX)
                    idx_reg <= idx_reg + 1'b1;
                if (!e_valid && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= idx_reg;
                end
                if (func_reg == brd_pkg::FUNC_RELEASE)
                begin
                    if (e_valid && owner_mem[idx_reg] == dev_reg)
                        valid_reg[idx_reg] <= 1'b0;
                end
                else if (stat.hit)
                begin
                    found_reg     <= 1'b1;
                    match_idx_reg <= idx_reg;
                    off_reg       <= diff_ab;
                end
            end
            else if (cmd.finish)
            begin
                if (is_reg && (len_reg != '0) && !found_reg && free_found_reg)
                    valid_reg[free_idx_reg] <= 1'b1;
            end
        end
    end

    // Table payload writes.
    always_ff @(posedge clk)
    begin
        if (cmd.finish && is_reg && (len_reg != '0) && !found_reg && free_found_reg)
        begin
            base_mem[free_idx_reg]  <= addr_reg;
            size_mem[free_idx_reg]  <= len_reg;
            owner_mem[free_idx_reg] <= dev_reg;
            space_mem[free_idx_reg] <= space_reg;
            rd_mem[free_idx_reg]    <= hrd_reg;
            wr_mem[free_idx_reg]    <= hwr_reg;
        end
    end

    // Request capture and result formation.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= func;
            space_reg <= space;
            addr_reg  <= address;
            len_reg   <= length;
            dev_reg   <= DEVICE_ID_BITS'(device_id);
            hrd_reg   <= has_read;
            hwr_reg   <= has_write;
            data_reg  <= write_data;
        end
        if (cmd.finish)
        begin
            tdev_reg  <= '0;
            roff_reg  <= '0;
            rdata_reg <= '0;
            rval_reg  <= '0;
            case (func_reg)
                brd_pkg::FUNC_REGISTER:
                begin
                    if (len_reg == '0)
                        status_reg <= brd_pkg::ST_ZERO_SIZE;
                    else if (found_reg)
                        status_reg <= brd_pkg::ST_OVERLAP;
                    else if (!free_found_reg)
                        status_reg <= brd_pkg::ST_FULL;
                    else
                        status_reg <= brd_pkg::ST_REGISTERED;
                end
                brd_pkg::FUNC_READ, brd_pkg::FUNC_WRITE:
                begin
                    if (!found_reg)
                    begin
                        status_reg <= brd_pkg::ST_UNMAPPED;
                        if (func_reg == brd_pkg::FUNC_READ)
                            rval_reg <= brd_pkg::ALL_ONES;
                    end
                    else
                    begin
                        tdev_reg <= 4'(owner_mem[match_idx_reg]);
                        roff_reg <= off_reg;
                        if (crosses)
                        begin
                            status_reg <= brd_pkg::ST_CROSSES;
                            if (func_reg == brd_pkg::FUNC_READ)
                                rval_reg <= brd_pkg::ALL_ONES;
                        end
                        else if (can)
                        begin
                            status_reg <= brd_pkg::ST_ROUTED;
                            if (func_reg == brd_pkg::FUNC_WRITE)
                                rdata_reg <= data_reg;
                        end
                        else
                            status_reg <= brd_pkg::ST_NO_HANDLER;
                    end
                end
                default:
                begin
                    status_reg <= brd_pkg::ST_RELEASED;
                end
            endcase
        end
    end

    assign status        = status_reg;
    assign target_device = tdev_reg;
    assign region_offset = roff_reg;
    assign routed_data   = rdata_reg;
    assign read_value    = rval_reg;

endmodule

// File: rtl/bus_region_decoder.sv
// Bus region decoder with overlap check.
// Requests arrive on the input channel as one word of func, space, address,
// length, device_id, has_read, has_write and write_data. Each request gives
// exactly one result word on the output channel: status, target_device,
// region_offset, routed_data and read_value.
// The controller walks the region table one entry per cycle. A request passes
// through S_IDLE, where it is accepted, then S_SCAN (a read or write stops at
// its matching region, a register at its first overlap), S_FINISH and S_OUT,
// where the result waits while the receiver stalls.
// One request is in work at a time; the next is accepted once the result
// has been taken.
// At reset every region is free and the output channel is empty. While the
// receiver stalls, the result word holds and no new request is accepted.
module bus_region_decoder #(
    parameter int REGIONS        = 16,
    parameter int DEVICE_ID_BITS = 4
) (
    input  logic  clk,
    input  logic  rst_n,
    brd_stream_if.sink   req,
    brd_stream_if.source rsp
);

    brd_pkg::cmd_t  cmd;
    brd_pkg::stat_t stat;

    logic [3:0]  status;
    logic [3:0]  target_device;
    logic [63:0] region_offset;
    logic [63:0] routed_data;
    logic [63:0] read_value;

    brd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Request word: {func, space, address, length, device_id, has_read,
    // has_write, write_data}, func in the top bits.
    brd_datapath #(
        .REGIONS        (REGIONS),
        .DEVICE_ID_BITS (DEVICE_ID_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .func          (req.data[200:199]),
        .space         (req.data[198]),
        .address       (req.data[197:134]),
        .length        (req.data[133:70]),
        .device_id     (req.data[69:66]),
        .has_read      (req.data[65]),
        .has_write     (req.data[64]),
        .write_data    (req.data[63:0]),
        .status        (status),
        .target_device (target_device),
        .region_offset (region_offset),
        .routed_data   (routed_data),
        .read_value    (read_value)
    );

    assign rsp.data = {status, target_device, region_offset, routed_data, read_value};

    // A new request is never taken while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n) rsp.valid |-> !req.ready)
        else $error("request accepted while a result is pending");

    // An unstalled result leaves the channel the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready) |=> !rsp.valid)
        else $error("result repeated");

    // Routed and no-handler accesses give a zero read value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (status == brd_pkg::ST_ROUTED || status == brd_pkg::ST_NO_HANDLER))
        |-> (read_value == '0))
        else $error("read value set on a matched access");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int REGIONS      = 16;
    localparam int RANDOM_ITEMS = 450;
    localparam int QUIET_ITEMS  = 60;
    localparam int IDLE_LIMIT   = 3000;

    // One request word, first field in the top bits.
    typedef struct packed {
        brd_pkg::func_t func;
        logic        space;
        logic [63:0] address;
        logic [63:0] length;
        logic [3:0]  device_id;
        logic        has_read;
        logic        has_write;
        logic [63:0] write_data;
    } request_t;

    // One result word, first field in the top bits.
    typedef struct packed {
        logic [3:0]  status;
        logic [3:0]  target_device;
        logic [63:0] region_offset;
        logic [63:0] routed_data;
        logic [63:0] read_value;
    } result_t;

    typedef struct {
        request_t req;
        bit       typed;
        result_t  res;
    } stim_row_t;

    typedef struct {
        bit      typed;
        result_t res;
    } typed_note_t;

    logic clk;
    logic rst_n;

    brd_stream_if #(.WIDTH($bits(request_t))) req ();
    brd_stream_if #(.WIDTH($bits(result_t)))  rsp ();

    bus_region_decoder uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Shadow copy of the region table.
    bit          region_valid [REGIONS];
    logic [63:0] region_base  [REGIONS];
    logic [63:0] region_size  [REGIONS];
    logic [3:0]  region_owner [REGIONS];
    logic        region_space [REGIONS];
    logic        region_rd    [REGIONS];
    logic        region_wr    [REGIONS];

    stim_row_t   directed_rows[$];
    typed_note_t typed_notes[$];
    result_t     pending_results[$];
    int          error_count;
    int          words_accepted;
    bit          quiet;
    bit          stimulus_done;
    bit          pressure_done;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Expected result of one request; also updates the shadow table.
    function automatic result_t decode_request(request_t r);
        result_t     res;
        int          slot;
        bit          hit;
        logic [63:0] off;
        res  = '0;
        slot = -1;
        hit  = 1'b0;
        case (r.func)
            brd_pkg::FUNC_REGISTER:
            begin
                if (r.length == 64'd0)
                    res.status = brd_pkg::ST_ZERO_SIZE;
                else
                begin
                    for (int i = 0; i < REGIONS; i++)
                    begin
                        if (region_valid[i] && region_space[i] == r.space)
                        begin
                            if (r.address >= region_base[i])
                                hit |= (r.address - region_base[i]) < region_size[i];
                            else
                                hit |= (region_base[i] - r.address) < r.length;
                        end
                    end
                    for (int i = REGIONS - 1; i >= 0; i--)
                        if (!region_valid[i])
                            slot = i;
                    if (hit)
                        res.status = brd_pkg::ST_OVERLAP;
                    else if (slot < 0)
                        res.status = brd_pkg::ST_FULL;
                    else
                    begin
                        region_valid[slot] = 1'b1;
                        region_base[slot]  = r.address;
                        region_size[slot]  = r.length;
                        region_owner[slot] = r.device_id;
                        region_space[slot] = r.space;
                        region_rd[slot]    = r.has_read;
                        region_wr[slot]    = r.has_write;
                        res.status         = brd_pkg::ST_REGISTERED;
                    end
                end
            end
            brd_pkg::FUNC_READ, brd_pkg::FUNC_WRITE:
            begin
                for (int i = 0; i < REGIONS; i++)
                begin
                    if (!hit && region_valid[i] && region_space[i] == r.space &&
                        r.address >= region_base[i] &&
                        (r.address - region_base[i]) < region_size[i])
                    begin
                        hit = 1'b1;
                        off = r.address - region_base[i];
                        res.target_device = region_owner[i];
                        res.region_offset = off;
                        if (r.length > region_size[i] - off)
                        begin
                            res.status = brd_pkg::ST_CROSSES;
                            if (r.func == brd_pkg::FUNC_READ)
                                res.read_value = brd_pkg::ALL_ONES;
                        end
                        else if (r.func == brd_pkg::FUNC_WRITE ? region_wr[i]
                                                               : region_rd[i])
                        begin
                            res.status = brd_pkg::ST_ROUTED;
                            if (r.func == brd_pkg::FUNC_WRITE)
                                res.routed_data = r.write_data;
                        end
                        else
                            res.status = brd_pkg::ST_NO_HANDLER;
                    end
                end
                if (!hit)
                begin
                    res.status = brd_pkg::ST_UNMAPPED;
                    if (r.func == brd_pkg::FUNC_READ)
                        res.read_value = brd_pkg::ALL_ONES;
                end
            end
            default:
            begin
                for (int i = 0; i < REGIONS; i++)
                    if (region_valid[i] && region_owner[i] == r.device_id)
                        region_valid[i] = 1'b0;
                res.status = brd_pkg::ST_RELEASED;
            end
        endcase
        return res;
    endfunction

    function automatic request_t make_request(brd_pkg::func_t f, logic sp,
                                              logic [63:0] addr,
                                              logic [63:0] len, logic [3:0] dev,
                                              logic rd, logic wr, logic [63:0] data);
        request_t r;
        r = '{f, sp, addr, len, dev, rd, wr, data};
        return r;
    endfunction

    function automatic result_t make_result(logic [3:0] st, logic [3:0] dev,
                                            logic [63:0] off, logic [63:0] rdata,
                                            logic [63:0] rval);
        result_t r;
        r = '{st, dev, off, rdata, rval};
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Random request, mostly aimed at regions the table holds.
    function automatic request_t random_request(int idx);
        request_t    r;
        int          pick;
        int          live[$];
        int          k;
        logic [63:0] len;
        r = make_request(brd_pkg::FUNC_READ, 1'($urandom_range(0, 1)), 64'd0, 64'd0,
                         4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                         1'($urandom_range(0, 1)), rand64());
        pick = int'($urandom_range(0, 99));
        for (int i = 0; i < REGIONS; i++)
            if (region_valid[i])
                live.push_back(i);
        if (pick < (idx < 150 ? 55 : 30))
        begin
            // Register: mostly a crowded low window, sometimes near the top.
            r.func = brd_pkg::FUNC_REGISTER;
            case ($urandom_range(0, 9))
                0: begin r.address = rand64(); r.length = rand64(); end
                1: begin r.address = brd_pkg::ALL_ONES - 64'($urandom_range(0, 255));
                         r.length = 64'($urandom_range(1, 300)); end
                2: begin r.address = 64'($urandom_range(0, 4095)); r.length = 64'd0; end
                default: begin r.address = 64'($urandom_range(0, 4095));
                               r.length = 64'($urandom_range(1, 64)); end
            endcase
        end
        else if (pick < 92)
        begin
            r.func = $urandom_range(0, 1) ? brd_pkg::FUNC_WRITE : brd_pkg::FUNC_READ;
            if (live.size() > 0 && $urandom_range(0, 9) < 8)
            begin
                k = live[$urandom_range(0, live.size() - 1)];
                r.space = region_space[k];
                if (region_size[k] > 64'd512)
                    r.address = region_base[k] + 64'($urandom_range(0, 511));
                else
                    r.address = region_base[k] +
                                64'($urandom_range(0, int'(region_size[k])));
                len = 64'($urandom_range(0, 16));
                if ($urandom_range(0, 9) == 0)
                    len = rand64();
                r.length = len;
            end
            else
            begin
                r.address = $urandom_range(0, 1) ? rand64()
                                                 : 64'($urandom_range(0, 4095));
                r.length  = $urandom_range(0, 1) ? rand64()
                                                 : 64'($urandom_range(0, 16));
            end
        end
        else
        begin
            r.func = brd_pkg::FUNC_RELEASE;
            if (live.size() > 0 && $urandom_range(0, 3) != 0)
                r.device_id = region_owner[live[$urandom_range(0, live.size() - 1)]];
        end
        return r;
    endfunction

    // Directed rows; a typed result only where it is plain to see.
    initial
    begin
        directed_rows = '{
            '{make_request(brd_pkg::FUNC_READ, 0, 0, 4, 0, 0, 0, 0), 1,
              make_result(brd_pkg::ST_UNMAPPED, 0, 0, 0, brd_pkg::ALL_ONES)},
            '{make_request(brd_pkg::FUNC_WRITE, 1, brd_pkg::ALL_ONES, brd_pkg::ALL_ONES,
                           0, 0, 0, brd_pkg::ALL_ONES), 1,
              make_result(brd_pkg::ST_UNMAPPED, 0, 0, 0, 0)},
            '{make_request(brd_pkg::FUNC_REGISTER, 0, 64'h40, 0, 2, 1, 1, 0), 1,
              make_result(brd_pkg::ST_ZERO_SIZE, 0, 0, 0, 0)},
            '{make_request(brd_pkg::FUNC_REGISTER, 0, 0, 64'h100, 3, 1, 0, 0), 1,
              make_result(brd_pkg::ST_REGISTERED, 0, 0, 0, 0)},
            '{make_request(brd_pkg::FUNC_REGISTER, 0, 64'h80, 64'h10, 4, 1, 1, 0), 1,
              make_result(brd_pkg::ST_OVERLAP, 0, 0, 0, 0)},
            '{make_request(brd_pkg::FUNC_REGISTER, 1, 64'h80, 64'h10, 5, 0, 1, 0), 1,
              make_result(brd_pkg::ST_REGISTERED, 0, 0, 0, 0)},
            '{make_request(brd_pkg::FUNC_REGISTER, 0, brd_pkg::ALL_ONES - 64'hF, 64'h10,
                           15, 1, 1, 0), 1,
              make_result(brd_pkg::ST_REGISTERED, 0, 0, 0, 0)},
            '{make_request(brd_pkg::FUNC_REGISTER, 0, 64'h100, brd_pkg::ALL_ONES,
                           7, 1, 1, 0), 0, '0},
            '{make_request(brd_pkg::FUNC_READ, 0, 64'h10, 8, 0, 0, 0, 0), 1,
              make_result(brd_pkg::ST_ROUTED, 3, 64'h10, 0, 0)},
            '{make_request(brd_pkg::FUNC_WRITE, 0, 64'h10, 8, 0, 0, 0,
                           64'h1234_5678_9ABC_DEF0), 1,
              make_result(brd_pkg::ST_NO_HANDLER, 3, 64'h10, 0, 0)},
            '{make_request(brd_pkg::FUNC_READ, 0, 64'hFC, 8, 0, 0, 0, 0), 1,
              make_result(brd_pkg::ST_CROSSES, 3, 64'hFC, 0, brd_pkg::ALL_ONES)},
            '{make_request(brd_pkg::FUNC_READ, 0, 64'h100, 0, 0, 0, 0, 0), 0, '0},
            '{make_request(brd_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0), 1,
              make_result(brd_pkg::ST_ROUTED, 3, 0, 0, 0)},
            '{make_request(brd_pkg::FUNC_READ, 0, brd_pkg::ALL_ONES, 1, 0, 0, 0, 0), 1,
              make_result(brd_pkg::ST_ROUTED, 15, 64'hF, 0, 0)},
            '{make_request(brd_pkg::FUNC_READ, 0, brd_pkg::ALL_ONES, brd_pkg::ALL_ONES,
                           0, 0, 0, 0), 1,
              make_result(brd_pkg::ST_CROSSES, 15, 64'hF, 0, brd_pkg::ALL_ONES)},
            '{make_request(brd_pkg::FUNC_WRITE, 1, 64'h8F, 1, 0, 0, 0,
                           brd_pkg::ALL_ONES), 1,
              make_result(brd_pkg::ST_ROUTED, 5, 64'hF, brd_pkg::ALL_ONES, 0)},
            '{make_request(brd_pkg::FUNC_READ, 1, 64'h80, 4, 0, 0, 0, 0), 1,
              make_result(brd_pkg::ST_NO_HANDLER, 5, 0, 0, 0)},
            '{make_request(brd_pkg::FUNC_RELEASE, 0, 0, 0, 3, 0, 0, 0), 1,
              make_result(brd_pkg::ST_RELEASED, 0, 0, 0, 0)},
            '{make_request(brd_pkg::FUNC_READ, 0, 64'h10, 8, 0, 0, 0, 0), 1,
              make_result(brd_pkg::ST_UNMAPPED, 0, 0, 0, brd_pkg::ALL_ONES)},
            '{make_request(brd_pkg::FUNC_RELEASE, 1, brd_pkg::ALL_ONES, brd_pkg::ALL_ONES,
                           9, 1, 1, brd_pkg::ALL_ONES), 1,
              make_result(brd_pkg::ST_RELEASED, 0, 0, 0, 0)}
        };
    end

    // Reset, then the request stream.
    initial
    begin
        request_t r;
        int       total;
        rst_n     <= 1'b0;
        req.valid <= 1'b0;
        req.data  <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        total = directed_rows.size() + RANDOM_ITEMS;
        for (int idx = 0; idx < total; idx++)
        begin
            quiet = (idx >= total - QUIET_ITEMS);
            if (idx < directed_rows.size())
            begin
                r = directed_rows[idx].req;
                typed_notes.push_back('{directed_rows[idx].typed, directed_rows[idx].res});
            end
            else
            begin
                r = random_request(idx - directed_rows.size());
                typed_notes.push_back('{1'b0, '0});
            end
            if (!quiet && $urandom_range(0, 4) == 0)
            begin
                req.valid <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
            end
            req.valid <= 1'b1;
            req.data  <= r;
            do
                @(posedge clk);
            while (!req.ready);
        end
        req.valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Receiver: random stalls, plus one long hold-off to fill the block.
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                if (stall_left == 0)
                    rsp.ready <= 1'b1;
            end
            else if (!pressure_done && words_accepted >= 100)
            begin
                pressure_done = 1'b1;
                stall_left    = 300;
                rsp.ready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall_left = int'($urandom_range(1, 18));
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // Predict each accepted request word.
    always @(posedge clk)
    begin
        typed_note_t note;
        result_t     predicted;
        if (rst_n && req.valid && req.ready)
        begin
            predicted = decode_request(request_t'(req.data));
            note      = typed_notes.pop_front();
            pending_results.push_back(note.typed ? note.res : predicted);
            words_accepted++;
        end
    end

    task automatic compare_field(string name, logic [63:0] expected, logic [63:0] actual);
        if (expected !== actual)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name,
                     expected, actual);
            error_count++;
        end
    endtask

    // Compare each result word with the oldest prediction.
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            got = result_t'(rsp.data);
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, got);
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("status", 64'(want.status), 64'(got.status));
                compare_field("target_device", 64'(want.target_device),
                              64'(got.target_device));
                compare_field("region_offset", want.region_offset, got.region_offset);
                compare_field("routed_data", want.routed_data, got.routed_data);
                compare_field("read_value", want.read_value, got.read_value);
            end
        end
    end

    // Watchdog on cycles with no word moving on either channel.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("%0t: timeout, %0d results outstanding", $time,
                         pending_results.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // End of run.
    initial
    begin
        wait (stimulus_done);
        wait (pending_results.size() == 0);
        repeat (25) @(posedge clk);
        if (error_count == 0 && pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: bus_region_decoder.f
rtl/brd_pkg.sv
rtl/brd_stream_if.sv
rtl/brd_ctrl.sv
rtl/brd_datapath.sv
rtl/bus_region_decoder.sv
sim/testbench.sv
